>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the frame receiver.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/ubx_fr_pkg.sv
// Types and constants for the binary navigation frame receiver.
// No dependencies; used by ubx_frame_receiver_core.
package ubx_fr_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND   = 8'h62;
  localparam logic [7:0]  CLASS_RESET   = 8'h01;
  localparam logic [15:0] MAX_PAYLOAD   = 16'd128;
  localparam logic [15:0] BUFFER_BYTES  = 16'd128;

  typedef enum logic [8:0] {
    ST_SYNC1   = 9'b000000001,
    ST_SYNC2   = 9'b000000010,
    ST_CLASS   = 9'b000000100,
    ST_ID      = 9'b000001000,
    ST_LEN_LO  = 9'b000010000,
    ST_LEN_HI  = 9'b000100000,
    ST_PAYLOAD = 9'b001000000,
    ST_CK_A    = 9'b010000000,
    ST_CK_B    = 9'b100000000
  } parse_state_t;

endpackage

>>> hw/rtl/ubx_frame_receiver_core.sv
// A result is registered and ready in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register takes a new
// result whenever it is empty or its result is taken in the same cycle.
// Reset (rst, synchronous, active high): parser waits for the first sync
// byte, checksums, counters and frame fields clear, accepted_class is 1.
`include "assert_macros.svh"

module ubx_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        store_valid,
  output logic [6:0]  store_index,
  output logic [7:0]  store_data,
  output logic        frame_end,
  output logic        frame_accepted,
  output logic [7:0]  frame_class,
  output logic [7:0]  frame_id,
  output logic [15:0] frame_length,
  output logic [15:0] good_packets,
  output logic [15:0] checksum_errors
);

  ubx_fr_pkg::parse_state_t state, state_next;
  logic [7:0]  accepted_class;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic        skip_frame, skip_frame_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] error_count, error_count_next;
  logic [15:0] packet_count, packet_count_next;
  logic        st_valid, st_end, st_acc;
  logic [6:0]  st_index;
  logic [7:0]  st_data;
  logic [7:0]  add_a;
  logic        accept;

  // State only moves on an accepted item, and an item is accepted only when
  // the previous result leaves, so the frame fields can come straight off state.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign add_a    = sum_a + rx_byte;

  always_comb begin
    state_next        = state;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    skip_frame_next   = skip_frame;
    class_reg_next    = class_reg;
    id_reg_next       = id_reg;
    length_reg_next   = length_reg;
    byte_counter_next = byte_counter;
    error_count_next  = error_count;
    packet_count_next = packet_count;
    st_valid          = 1'b0;
    st_index          = '0;
    st_data           = '0;
    st_end            = 1'b0;
    st_acc            = 1'b0;
    unique case (state)
      ubx_fr_pkg::ST_SYNC1: begin
        if (rx_byte == ubx_fr_pkg::SYNC_FIRST) begin
          skip_frame_next = 1'b0;
          state_next      = ubx_fr_pkg::ST_SYNC2;
        end
      end
      ubx_fr_pkg::ST_SYNC2: begin
        // a failed second sync is not retried as a first sync
        state_next = (rx_byte == ubx_fr_pkg::SYNC_SECOND) ? ubx_fr_pkg::ST_CLASS
                                                          : ubx_fr_pkg::ST_SYNC1;
      end
      ubx_fr_pkg::ST_CLASS: begin
        state_next     = ubx_fr_pkg::ST_ID;
        class_reg_next = rx_byte;
        sum_a_next     = rx_byte;
        sum_b_next     = rx_byte;
        if (rx_byte != accepted_class) skip_frame_next = 1'b1;
      end
      ubx_fr_pkg::ST_ID: begin
        state_next  = ubx_fr_pkg::ST_LEN_LO;
        sum_a_next  = add_a;
        sum_b_next  = sum_b + add_a;
        id_reg_next = rx_byte;
      end
      ubx_fr_pkg::ST_LEN_LO: begin
        state_next      = ubx_fr_pkg::ST_LEN_HI;
        sum_a_next      = add_a;
        sum_b_next      = sum_b + add_a;
        length_reg_next = {8'h00, rx_byte};
      end
      ubx_fr_pkg::ST_LEN_HI: begin
        sum_a_next        = add_a;
        sum_b_next        = sum_b + add_a;
        length_reg_next   = {rx_byte, length_reg[7:0]};
        byte_counter_next = '0;
        if (length_reg_next > ubx_fr_pkg::MAX_PAYLOAD) skip_frame_next = 1'b1;
        // zero length goes straight to the checksum
        state_next = (length_reg_next == 16'd0) ? ubx_fr_pkg::ST_CK_A
                                                : ubx_fr_pkg::ST_PAYLOAD;
      end
      ubx_fr_pkg::ST_PAYLOAD: begin
        sum_a_next = add_a;
        sum_b_next = sum_b + add_a;
        if (byte_counter < ubx_fr_pkg::BUFFER_BYTES) begin
          st_valid = 1'b1;
          st_index = byte_counter[6:0];
          st_data  = rx_byte;
        end
        byte_counter_next = byte_counter + 16'd1;
        if (byte_counter_next >= length_reg) state_next = ubx_fr_pkg::ST_CK_A;
      end
      ubx_fr_pkg::ST_CK_A: begin
        state_next = ubx_fr_pkg::ST_CK_B;
        if (sum_a != rx_byte) begin
          skip_frame_next  = 1'b1;
          error_count_next = error_count + 16'd1;
        end
      end
      ubx_fr_pkg::ST_CK_B: begin
        state_next = ubx_fr_pkg::ST_SYNC1;
        st_end     = 1'b1;
        if (sum_b != rx_byte) begin
          error_count_next = error_count + 16'd1;
        end else begin
          packet_count_next = packet_count + 16'd1;
          st_acc            = !skip_frame;
        end
      end
      default: begin
        state_next = ubx_fr_pkg::ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_class <= ubx_fr_pkg::CLASS_RESET;
    end else if (cfg_wr_en) begin
      accepted_class <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ubx_fr_pkg::ST_SYNC1;
      sum_a        <= '0;
      sum_b        <= '0;
      skip_frame   <= 1'b0;
      class_reg    <= '0;
      id_reg       <= '0;
      length_reg   <= '0;
      byte_counter <= '0;
      error_count  <= '0;
      packet_count <= '0;
    end else if (accept) begin
      state        <= state_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      skip_frame   <= skip_frame_next;
      class_reg    <= class_reg_next;
      id_reg       <= id_reg_next;
      length_reg   <= length_reg_next;
      byte_counter <= byte_counter_next;
      error_count  <= error_count_next;
      packet_count <= packet_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      store_valid    <= 1'b0;
      frame_end      <= 1'b0;
      frame_accepted <= 1'b0;
    end else if (accept) begin
      out_valid      <= 1'b1;
      store_valid    <= st_valid;
      frame_end      <= st_end;
      frame_accepted <= st_acc;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload fields of the result need no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      store_index <= st_index;
      store_data  <= st_data;
    end
  end

  assign frame_class     = class_reg;
  assign frame_id        = id_reg;
  assign frame_length    = length_reg;
  assign good_packets    = packet_count;
  assign checksum_errors = error_count;

  `ASSERT_CLK(a_store_not_end, out_valid |-> !(store_valid && frame_end),
              "payload store and frame end in the same item")
  `ASSERT_CLK(a_acc_needs_end, out_valid && frame_accepted |-> frame_end,
              "frame accepted without frame end")
  `ASSERT_CLK(a_pkt_at_end, !$stable(packet_count) |-> out_valid && frame_end,
              "packet count moved outside a frame end")
  `ASSERT_CLK(a_err_step, !$stable(error_count) |-> error_count == $past(error_count) + 16'd1,
              "error count moved by more than one")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid,
                 "result present right after reset")

endmodule
